[sv/lzsb_pkg.sv]
// Shared types, constants and codes for the leaf zone statistics and Bloom block.
package lzsb_pkg;

  // FNV-1a 64-bit offset basis; the prime is 2^40 + 0x1B3
  localparam logic [63:0] FNV_BASIS     = 64'hcbf29ce484222325;
  localparam int          FNV_SHIFT     = 40;
  localparam logic [8:0]  FNV_PRIME_LOW = 9'h1B3;

  // Murmur3 64-bit finaliser
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  localparam logic [15:0] RUN_LIMIT  = 16'hFFFF;
  localparam logic [2:0]  MAX_HASHES = 3'd4;

  // Key type codes
  localparam logic [1:0] KT_INT16 = 2'd0;
  localparam logic [1:0] KT_INT32 = 2'd1;
  localparam logic [1:0] KT_INT64 = 2'd2;
  localparam logic [1:0] KT_RAW   = 2'd3;

  // Register indexes (byte address 4*index)
  localparam logic [1:0] REG_KEY_TYPE     = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH   = 2'd1;
  localparam logic [1:0] REG_BLOOM_ENABLE = 2'd2;
  localparam logic [1:0] REG_BLOOM_HASHES = 2'd3;

  // Finaliser passes: xor-shift, C1 multiply, xor-shift, C2 multiply, xor-shift
  localparam logic [1:0] MIX_LAST = 2'd2;

  typedef struct packed {
    logic [1:0] key_type;
    logic [3:0] key_length;
    logic       bloom_enable;
    logic [2:0] bloom_hashes;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FNV,
    OP_XS,
    OP_M0,
    OP_M1,
    OP_M2,
    OP_M3,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] byte_idx;
    logic [1:0] mix_idx;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_stall;
  } sts_t;

endpackage

[sv/lzsb_regs.sv]
// Configuration registers behind the APB-style port.
module lzsb_regs import lzsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [1:0] key_type_r;
  logic [3:0] key_length_r;
  logic       bloom_enable_r;
  logic [2:0] bloom_hashes_r;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_type_r     <= KT_INT32;
      key_length_r   <= 4'd4;
      bloom_enable_r <= 1'b0;
      bloom_hashes_r <= 3'd2;
    end else if (wr) begin
      case (paddr[3:2])
        REG_KEY_TYPE:     key_type_r     <= pwdata[1:0];
        REG_KEY_LENGTH:   key_length_r   <= pwdata[3:0];
        REG_BLOOM_ENABLE: bloom_enable_r <= pwdata[0];
        REG_BLOOM_HASHES: bloom_hashes_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      REG_KEY_TYPE:     prdata = {30'b0, key_type_r};
      REG_KEY_LENGTH:   prdata = {28'b0, key_length_r};
      REG_BLOOM_ENABLE: prdata = {31'b0, bloom_enable_r};
      REG_BLOOM_HASHES: prdata = {29'b0, bloom_hashes_r};
      default:          prdata = 32'b0;
    endcase
  end

  assign cfg = '{key_type: key_type_r, key_length: key_length_r,
                 bloom_enable: bloom_enable_r, bloom_hashes: bloom_hashes_r};

endmodule

[sv/lzsb_ctrl.sv]
// Sequencer: steps each key through FNV, the finaliser xor-shifts and multiplies and the update.
module lzsb_ctrl import lzsb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_FNV, S_XS, S_M0, S_M1, S_M2, S_M3, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] mix_r, mix_nxt;
  logic       rdy_r, rdy_nxt;

  assign in_tready = rdy_r;

  // next state and command
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    mix_nxt      = mix_r;
    cmd.op       = OP_NONE;
    cmd.byte_idx = idx_r;
    cmd.mix_idx  = mix_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && rdy_r) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_FNV;
          idx_nxt   = 3'd0;
        end
      end
      S_FNV: begin
        cmd.op  = OP_FNV;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          state_nxt = S_XS;
          mix_nxt   = 2'd0;
        end
      end
      S_XS: begin
        cmd.op    = OP_XS;
        state_nxt = (mix_r == MIX_LAST) ? S_FIN : S_M0;
      end
      S_M0: begin
        cmd.op    = OP_M0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.op    = OP_M3;
        state_nxt = S_XS;
        mix_nxt   = mix_r + 2'd1;
      end
      S_FIN: begin
        // a closing key waits for the output register to free up
        if (!(sts.last && sts.out_stall)) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    rdy_nxt = (state_nxt == S_IDLE);
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 3'd0;
      mix_r   <= 2'd0;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      mix_r   <= mix_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

endmodule

[sv/lzsb_dp.sv]
// Datapath: hashing, leaf statistics and the output register.
module lzsb_dp import lzsb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  logic [63:0]  key_in,
  input  logic         last_in,
  input  logic [31:0]  block_in,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata
);

  // mask of the low len bytes
  function automatic logic [63:0] len_mask(input logic [3:0] len);
    logic [63:0] m;
    if (len >= 4'd8) m = '1;
    else             m = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
    return m;
  endfunction

  function automatic logic [31:0] range_value(input logic [63:0] k, input cfg_t c);
    logic [3:0]  len;
    logic [63:0] m;
    logic [31:0] rv;
    len = (c.key_length > 4'd4) ? 4'd4 : c.key_length;
    m   = len_mask(len);
    case (c.key_type)
      KT_INT16: rv = {{16{k[15]}}, k[15:0]};
      KT_INT32: rv = k[31:0];
      KT_INT64: rv = k[63:32];
      default:  rv = k[31:0] & m[31:0];
    endcase
    return rv;
  endfunction

  function automatic logic [63:0] hash_value(input logic [63:0] k, input cfg_t c);
    logic [63:0] hv;
    case (c.key_type)
      KT_INT16: hv = {{48{k[15]}}, k[15:0]};
      KT_INT32: hv = {{32{k[31]}}, k[31:0]};
      KT_INT64: hv = k;
      default:  hv = k & len_mask(c.key_length);
    endcase
    return hv;
  endfunction

  // positions (h1 + i*h2) mod 64; only the low six bits take part
  function automatic logic [63:0] bloom_bits(input logic [5:0] h1, input logic [5:0] h2,
                                             input logic [2:0] n);
    logic [5:0]  pos;
    logic [63:0] w;
    w = 64'd0;
    if (n != 3'd0 && n <= MAX_HASHES) begin
      for (int i = 0; i < 4; i++) begin
        pos = h1 + 6'(i) * h2;
        if (3'(i) < n) w = w | (64'd1 << pos);
      end
    end
    return w;
  endfunction

  logic [63:0] key_r, prev_r, h_r, w_r, acc_r, prod_r, bloom_r;
  logic [31:0] blk_r, cnt_r, first_r;
  logic [15:0] run_r;
  logic        last_r;

  logic [31:0] ob_r, omin_r, omax_r, ocnt_r;
  logic [15:0] orun_r;
  logic [63:0] obloom_r;
  logic        out_valid_r, out_valid_nxt;

  logic [63:0] hv, hv_sh, fnv_x, fnv_nxt, xs_src, xs_val, mix_c, prod_c, lm, bloom_c;
  logic [31:0] mul_a, mul_b, rv, first_c, cnt_c;
  logic [15:0] run_c;
  logic        fin_last;

  // FNV-1a byte step; the prime multiply is a shift plus a 9-bit product
  assign hv      = hash_value(key_r, cfg);
  assign hv_sh   = hv >> {cmd.byte_idx, 3'b000};
  assign fnv_x   = h_r ^ {56'b0, hv_sh[7:0]};
  assign fnv_nxt = (fnv_x << FNV_SHIFT) + fnv_x * {55'b0, FNV_PRIME_LOW};

  // finaliser xor-shift, first pass works on the FNV result
  assign xs_src = (cmd.mix_idx == 2'd0) ? h_r : w_r;
  assign xs_val = xs_src ^ (xs_src >> MIX_SHIFT);

  // 64-bit low-half product from three 32x32 partial products
  assign mix_c = cmd.mix_idx[0] ? MIX_C2 : MIX_C1;
  always_comb begin
    case (cmd.op)
      OP_M1: begin
        mul_a = w_r[31:0];
        mul_b = mix_c[63:32];
      end
      OP_M2: begin
        mul_a = w_r[63:32];
        mul_b = mix_c[31:0];
      end
      default: begin
        mul_a = w_r[31:0];
        mul_b = mix_c[31:0];
      end
    endcase
  end
  assign prod_c = {32'b0, mul_a} * {32'b0, mul_b};

  // statistics update for the current key
  assign rv      = range_value(key_r, cfg);
  assign lm      = len_mask(cfg.key_length);
  assign first_c = (cnt_r == 32'd0) ? rv : first_r;
  assign cnt_c   = (cnt_r == '1) ? cnt_r : cnt_r + 32'd1;
  always_comb begin
    if (cnt_r == 32'd0)
      run_c = 16'd1;
    else if (((key_r & lm) != (prev_r & lm)) && (run_r != RUN_LIMIT))
      run_c = run_r + 16'd1;
    else
      run_c = run_r;
  end
  assign bloom_c  = bloom_r | bloom_bits(h_r[5:0], w_r[5:0], cfg.bloom_hashes);
  assign fin_last = (cmd.op == OP_FIN) && last_r;

  // hashing registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        key_r  <= key_in;
        blk_r  <= block_in;
        last_r <= last_in;
        h_r    <= FNV_BASIS;
      end
      OP_FNV: h_r <= fnv_nxt;
      OP_XS:  w_r <= xs_val;
      OP_M0:  prod_r <= prod_c;
      OP_M1: begin
        acc_r  <= prod_r;
        prod_r <= prod_c;
      end
      OP_M2: begin
        acc_r  <= acc_r + {prod_r[31:0], 32'b0};
        prod_r <= prod_c;
      end
      OP_M3:  w_r <= acc_r + {prod_r[31:0], 32'b0};
      default: ;
    endcase
  end

  // leaf state, cleared after the closing key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 32'd0;
      first_r <= 32'd0;
      prev_r  <= 64'd0;
      run_r   <= 16'd0;
      bloom_r <= 64'd0;
    end else if (cmd.op == OP_FIN) begin
      if (last_r) begin
        cnt_r   <= 32'd0;
        first_r <= 32'd0;
        prev_r  <= 64'd0;
        run_r   <= 16'd0;
        bloom_r <= 64'd0;
      end else begin
        cnt_r   <= cnt_c;
        first_r <= first_c;
        prev_r  <= key_r;
        run_r   <= run_c;
        bloom_r <= bloom_c;
      end
    end
  end

  // output register
  always_comb begin
    if (fin_last)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (fin_last) begin
      ob_r     <= blk_r;
      omin_r   <= first_c;
      omax_r   <= rv;
      ocnt_r   <= cnt_c;
      orun_r   <= run_c;
      obloom_r <= cfg.bloom_enable ? bloom_c : 64'd0;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {obloom_r, orun_r, ocnt_r, omax_r, omin_r, ob_r};
  assign sts.last      = last_r;
  assign sts.out_stall = out_valid_r && !out_tready;

`ifndef SYNTHESIS
  // a closing key is only retired into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fin_last |-> !(out_valid_r && !out_tready))
    else $error("result overwritten while stalled");

  // a closing key shows its result in the next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    fin_last |=> out_valid_r)
    else $error("result not presented");

  // leaf state returns to zero after the closing key
  a_leaf_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fin_last |=> (cnt_r == 32'd0) && (run_r == 16'd0) && (bloom_r == 64'd0))
    else $error("leaf state not cleared");

  // a shown result always counts at least one row and one run
  a_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ocnt_r != 32'd0) && (orun_r != 16'd0))
    else $error("empty result");
`endif

endmodule

[sv/leaf_zone_stats_bloom.sv]
// Top level: zone-map statistics and a 64-bit Bloom word over the keys of a leaf.
//
//  channel  | direction | handshake                        | payload
//  ---------+-----------+----------------------------------+-------------------------------
//  in_      | in        | in_tvalid / in_tready            | in_tdata (96), in_tlast
//  out_     | out       | out_tvalid / out_tready          | out_tdata (208)
//  cfg_     | in        | cfg_psel, cfg_penable, cfg_pready| cfg_paddr, cfg_pwdata, cfg_prdata
//
// Each key runs from acceptance to the next ready through eight FNV byte steps, three
// finaliser xor-shifts and two 64-bit multiplies, each from three partial products on one
// shared 32x32 multiplier, the update step and the idle state in which the next key is taken.
// Reset is synchronous and active low; in_tready is low in reset and rises once it is released.
// A closing key waits in its update cycle while the previous result is still unread; the
// next key is accepted while a result waits in the output register.
module leaf_zone_stats_bloom import lzsb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,    // key_bytes[63:0], page_block[95:64]
  input  logic         in_tlast,    // leaf_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata,   // out_block[31:0], min_key[63:32], max_key[95:64],
                                    // rows[127:96], runs[143:128],
                                    // bloom_word[207:144]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  lzsb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lzsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzsb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .key_in     (in_tdata[63:0]),
    .last_in    (in_tlast),
    .block_in   (in_tdata[95:64]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
